// ===== rtl/core/bfra_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit range allocator package
// Shared widths, command and status codes, and reset defaults.
// ----------------------------------------------------------------------------
package bfra_pkg;

   localparam int MAX_RANGES_DEF  = 16;
   localparam int OFFSET_BITS_DEF = 32;
   localparam int ALIGN_BITS      = 17;
   localparam int STATUS_BITS     = 2;
   localparam longint unsigned CAPACITY_RESET = 64'd1048576;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;

endpackage

// ===== rtl/core/bfra_modulo.sv =====
// ----------------------------------------------------------------------------
// Range allocator remainder unit
// Restoring bit-serial remainder of an offset by an alignment, one bit a cycle.
// ----------------------------------------------------------------------------
module bfra_modulo #(
   parameter int OFFSET_BITS = bfra_pkg::OFFSET_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [OFFSET_BITS-1:0]          dividend,
   input  logic [bfra_pkg::ALIGN_BITS-1:0] divisor,
   output logic                            done,
   output logic [bfra_pkg::ALIGN_BITS-1:0] remainder
);

   localparam int CW = $clog2(OFFSET_BITS + 1);
   localparam int AB = bfra_pkg::ALIGN_BITS;

   logic [OFFSET_BITS-1:0] shift_ff, shift_in;
   logic [AB:0]            rem_ff, rem_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [AB:0]            trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[AB-1:0], shift_ff[OFFSET_BITS-1]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = CW'(OFFSET_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[AB-1:0];

endmodule

// ===== rtl/core/best_fit_range_allocator.sv =====
// ----------------------------------------------------------------------------
// Best-fit range allocator
// Offset-sorted free range table in a memory, best-fit allocate and
// coalescing free.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// req_      in         tuser cmd; tdata size, align, offset_in
// rsp_      out        tdata status, offset_out, free_bytes, largest, peak
// csr_      in         capacity write
// An allocate scans the table once, per entry one memory read and one remainder
// pass. A commit or free may then run a shift pass that moves entries one at a
// time, each moved entry read in ST_SHRD and written in ST_SHWR; a final scan
// then finds the largest range. Items run one at a time. Reset and capacity writes
// rebuild the table as one range at entry 0 (count 0 after a zero capacity write).
// A result waits in its register until taken; the next request is then taken.
// ----------------------------------------------------------------------------
module best_fit_range_allocator #(
   parameter int MAX_RANGES  = bfra_pkg::MAX_RANGES_DEF,
   parameter int OFFSET_BITS = bfra_pkg::OFFSET_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_tuser, // cmd
   // size_bytes, align_bytes, offset_in, zero fill
   input  logic [((2*OFFSET_BITS+1+bfra_pkg::ALIGN_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status, offset_out, free_bytes, largest_free, peak_bytes, zero fill
   output logic [((4*OFFSET_BITS+3+bfra_pkg::STATUS_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [OFFSET_BITS:0] csr_wr_data
);

   localparam int OB = OFFSET_BITS;
   localparam int LB = OFFSET_BITS + 1;
   localparam int AB = bfra_pkg::ALIGN_BITS;
   localparam int SB = bfra_pkg::STATUS_BITS;
   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int REQW = ((2*OFFSET_BITS+1+AB+7)/8)*8;
   localparam int RSPW = ((4*OFFSET_BITS+3+SB+7)/8)*8;
   localparam logic [LB-1:0] LEN_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_MOD, ST_EVAL, ST_COMMIT, ST_FRD, ST_FEVAL,
      ST_SHRD, ST_SHWR, ST_LRD, ST_LEVAL, ST_RSP
   } state_type;

   logic [OB-1:0] mem_start [MAX_RANGES];
   logic [LB-1:0] mem_len   [MAX_RANGES];
   logic [OB-1:0] rd_start_ff;
   logic [LB-1:0] rd_len_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [OB-1:0] wr_start;
   logic [LB-1:0] wr_len;

   state_type state_ff;
   logic [LB-1:0] capacity_ff, alloc_ff, peak_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic          cmd_ff;
   logic [LB-1:0] size_ff;
   logic [AB-1:0] align_ff;
   logic [OB-1:0] off_ff;
   logic          found_ff;
   logic [IW-1:0] best_ff;
   logic [OB:0]   best_al_ff;
   logic [LB-1:0] best_slack_ff, best_len_ff;
   logic [OB-1:0] best_start_ff;
   logic [OB-1:0] prev_start_ff;
   logic [LB-1:0] prev_len_ff;
   logic [SB-1:0] status_ff;
   logic [OB-1:0] off_out_ff;
   logic [LB-1:0] largest_ff;
   logic          rsp_valid_ff;
   logic          mod_go_ff;
   // shift pass: direction up (insert) or down (remove), bounds
   logic          sh_up_ff;
   logic [CW-1:0] sh_end_ff;
   logic [OB-1:0] ins_start_ff;
   logic [LB-1:0] ins_len_ff;
   logic [CW-1:0] ins_pos_ff;

   logic          mod_start, mod_done;
   logic [AB-1:0] mod_rem;

   bfra_modulo #(.OFFSET_BITS(OFFSET_BITS)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(rd_start_ff),
      .divisor(align_ff), .done(mod_done), .remainder(mod_rem)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_addr] <= wr_start;
         mem_len[wr_addr]   <= wr_len;
      end
      rd_start_ff <= mem_start[rd_addr];
      rd_len_ff   <= mem_len[rd_addr];
   end

   // evaluation of the entry just read
   logic [OB:0]   al_cand, lead_c;
   logic          fits;
   logic [LB-1:0] waste_c;
   always_comb begin
      al_cand = {1'b0, rd_start_ff} + ((mod_rem == '0) ? '0 : LB'(align_ff - mod_rem));
      lead_c  = al_cand - {1'b0, rd_start_ff};
      fits    = !al_cand[OB] && (lead_c <= rd_len_ff) && (size_ff <= rd_len_ff - lead_c);
      waste_c = rd_len_ff - lead_c - size_ff;
   end

   // commit of an allocate
   logic [LB-1:0] c_lead, c_trail;
   logic [OB+1:0] c_tail;
   logic          c_keep;
   always_comb begin
      c_lead  = best_al_ff - {1'b0, best_start_ff};
      c_trail = best_len_ff - c_lead - size_ff;
      c_tail  = {1'b0, best_al_ff} + {1'b0, size_ff};
      c_keep  = (c_trail != '0) && (c_tail <= (OB+2)'({OB{1'b1}}));
   end

   logic [LB:0]   sum_alloc;
   logic [LB:0]   f_end;
   logic          f_mnext, f_mprev, f_stop;
   logic [LB:0]   f_len, f_plen;
   always_comb begin
      sum_alloc = {1'b0, alloc_ff} + {1'b0, size_ff};
      f_stop  = (idx_ff >= count_ff) || (rd_start_ff >= off_ff);
      f_end   = {2'b0, off_ff} + {1'b0, size_ff};
      f_mnext = (idx_ff < count_ff) && (f_end == {2'b0, rd_start_ff});
      f_mprev = (idx_ff != '0) &&
                (({2'b0, prev_start_ff} + {1'b0, prev_len_ff}) == {2'b0, off_ff});
      f_len   = {1'b0, size_ff} + (f_mnext ? {1'b0, rd_len_ff} : '0);
      if (f_len[LB]) f_len = {1'b0, LEN_MAX};
      f_plen  = {1'b0, prev_len_ff} + f_len;
      if (f_plen[LB]) f_plen = {1'b0, LEN_MAX};
   end

   always_comb begin
      rd_addr = idx_ff[IW-1:0];
      if (state_ff == ST_SHRD) begin
         rd_addr = sh_up_ff ? IW'(idx_ff - 1'b1) : IW'(idx_ff + 1'b1);
      end
   end

   always_comb begin
      mod_start = mod_go_ff;
   end

   always_comb begin
      wr_en = 1'b0; wr_addr = '0; wr_start = '0; wr_len = '0;
      if (reset || csr_wr_en) begin
         wr_en = 1'b1;
         wr_len = reset ? LB'(bfra_pkg::CAPACITY_RESET) : csr_wr_data;
      end else if (state_ff == ST_COMMIT && found_ff) begin
         wr_addr = best_ff;
         if (c_lead != '0) begin
            wr_en = !(c_keep && count_ff >= CW'(MAX_RANGES));
            wr_start = best_start_ff; wr_len = c_lead;
         end else if (c_keep) begin
            wr_en = 1'b1; wr_start = c_tail[OB-1:0]; wr_len = c_trail;
         end
      end else if (state_ff == ST_FEVAL && f_stop) begin
         if (f_mprev) begin
            wr_en = 1'b1; wr_addr = IW'(idx_ff - 1'b1);
            wr_start = prev_start_ff; wr_len = f_plen[LB-1:0];
         end else if (f_mnext) begin
            wr_en = 1'b1; wr_addr = idx_ff[IW-1:0];
            wr_start = off_ff; wr_len = f_len[LB-1:0];
         end
      end else if (state_ff == ST_SHWR) begin
         wr_en = 1'b1; wr_addr = idx_ff[IW-1:0];
         if (sh_up_ff && idx_ff == ins_pos_ff) begin
            wr_start = ins_start_ff; wr_len = ins_len_ff;
         end else begin
            wr_start = rd_start_ff; wr_len = rd_len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_go_ff    <= 1'b0;
         capacity_ff  <= reset ? LB'(bfra_pkg::CAPACITY_RESET) : csr_wr_data;
         count_ff     <= (reset || csr_wr_data != '0) ? CW'(1) : '0;
         alloc_ff     <= '0;
         peak_ff      <= '0;
         idx_ff       <= '0;
      end else begin
         mod_go_ff <= (state_ff == ST_RD);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && !rsp_valid_ff) begin
                  cmd_ff   <= req_tuser;
                  size_ff  <= req_tdata[LB-1:0];
                  align_ff <= (req_tdata[LB+AB-1:LB] == '0) ? AB'(1) : req_tdata[LB+AB-1:LB];
                  off_ff   <= req_tdata[LB+AB+OB-1:LB+AB];
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  status_ff  <= bfra_pkg::STATUS_OK;
                  off_out_ff <= '0;
                  largest_ff <= '0;
                  if (req_tuser == bfra_pkg::CMD_FREE) begin
                     if (req_tdata[LB-1:0] == '0) state_ff <= ST_LRD;
                     else state_ff <= ST_FRD;
                  end else begin
                     state_ff <= (count_ff == '0) ? ST_COMMIT : ST_RD;
                  end
               end
            end
            ST_RD: state_ff <= ST_MOD;
            ST_MOD: if (mod_done) state_ff <= ST_EVAL;
            ST_EVAL: begin
               if (fits && (!found_ff || waste_c < best_slack_ff ||
                            (waste_c == best_slack_ff && al_cand < best_al_ff))) begin
                  found_ff <= 1'b1; best_ff <= idx_ff[IW-1:0];
                  best_al_ff <= al_cand; best_slack_ff <= waste_c;
                  best_start_ff <= rd_start_ff; best_len_ff <= rd_len_ff;
               end
               idx_ff <= idx_ff + 1'b1;
               state_ff <= (idx_ff + 1'b1 >= count_ff) ? ST_COMMIT : ST_RD;
            end
            ST_COMMIT: begin
               if (!found_ff) begin
                  status_ff <= bfra_pkg::STATUS_NO_FIT;
                  idx_ff <= '0; state_ff <= ST_LRD;
               end else if (c_lead != '0 && c_keep && count_ff >= CW'(MAX_RANGES)) begin
                  status_ff <= bfra_pkg::STATUS_FULL;
                  idx_ff <= '0; state_ff <= ST_LRD;
               end else begin
                  off_out_ff <= best_al_ff[OB-1:0];
                  alloc_ff <= sum_alloc[LB] ? LEN_MAX : sum_alloc[LB-1:0];
                  if ((sum_alloc[LB] ? LEN_MAX : sum_alloc[LB-1:0]) > peak_ff)
                     peak_ff <= sum_alloc[LB] ? LEN_MAX : sum_alloc[LB-1:0];
                  if (c_lead != '0 && c_keep) begin
                     sh_up_ff <= 1'b1; ins_pos_ff <= CW'(best_ff) + 1'b1;
                     ins_start_ff <= c_tail[OB-1:0]; ins_len_ff <= c_trail;
                     sh_end_ff <= CW'(best_ff) + 1'b1;
                     idx_ff <= count_ff; count_ff <= count_ff + 1'b1;
                     state_ff <= ST_SHRD;
                  end else if (c_lead == '0 && !c_keep) begin
                     sh_up_ff <= 1'b0;
                     sh_end_ff <= count_ff - 1'b1; count_ff <= count_ff - 1'b1;
                     if (CW'(best_ff) + 1'b1 >= count_ff) begin
                        idx_ff <= '0; state_ff <= ST_LRD;
                     end else begin
                        idx_ff <= CW'(best_ff); state_ff <= ST_SHRD;
                     end
                  end else begin
                     idx_ff <= '0; state_ff <= ST_LRD;
                  end
               end
            end
            ST_FRD: state_ff <= ST_FEVAL;
            ST_FEVAL: begin
               if (!f_stop) begin
                  prev_start_ff <= rd_start_ff; prev_len_ff <= rd_len_ff;
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= ST_FRD;
               end else if (!f_mnext && !f_mprev && count_ff >= CW'(MAX_RANGES)) begin
                  status_ff <= bfra_pkg::STATUS_FULL;
                  idx_ff <= '0; state_ff <= ST_LRD;
               end else begin
                  alloc_ff <= (alloc_ff >= size_ff) ? alloc_ff - size_ff : '0;
                  if (f_mprev && f_mnext) begin
                     sh_up_ff <= 1'b0; sh_end_ff <= count_ff - 1'b1;
                     count_ff <= count_ff - 1'b1;
                     if (idx_ff + 1'b1 >= count_ff) begin
                        idx_ff <= '0; state_ff <= ST_LRD;
                     end else state_ff <= ST_SHRD;
                  end else if (f_mprev || f_mnext) begin
                     idx_ff <= '0; state_ff <= ST_LRD;
                  end else begin
                     sh_up_ff <= 1'b1; ins_pos_ff <= idx_ff;
                     ins_start_ff <= off_ff; ins_len_ff <= f_len[LB-1:0];
                     sh_end_ff <= idx_ff;
                     idx_ff <= count_ff; count_ff <= count_ff + 1'b1;
                     state_ff <= (idx_ff == count_ff) ? ST_SHWR : ST_SHRD;
                  end
               end
            end
            ST_SHRD: state_ff <= ST_SHWR;
            ST_SHWR: begin
               if (sh_up_ff) begin
                  if (idx_ff == sh_end_ff) begin
                     idx_ff <= '0; state_ff <= ST_LRD;
                  end else begin
                     idx_ff <= idx_ff - 1'b1;
                     state_ff <= (idx_ff - 1'b1 == ins_pos_ff) ? ST_SHWR : ST_SHRD;
                  end
               end else begin
                  if (idx_ff + 1'b1 >= sh_end_ff) begin
                     idx_ff <= '0; state_ff <= ST_LRD;
                  end else begin
                     idx_ff <= idx_ff + 1'b1; state_ff <= ST_SHRD;
                  end
               end
            end
            ST_LRD: state_ff <= (idx_ff >= count_ff) ? ST_RSP : ST_LEVAL;
            ST_LEVAL: begin
               if (rd_len_ff > largest_ff) largest_ff <= rd_len_ff;
               idx_ff <= idx_ff + 1'b1;
               state_ff <= ST_LRD;
            end
            ST_RSP: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   logic [LB-1:0] free_c;
   assign free_c = (capacity_ff >= alloc_ff) ? capacity_ff - alloc_ff : '0;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSPW'({peak_ff, largest_ff, free_c, off_out_ff, status_ff});

   logic unused_req;
   assign unused_req = ^req_tdata[REQW-1:LB+AB+OB] ^ cmd_ff;

endmodule

// ===== tb/tb_best_fit_range_allocator.sv =====
// ----------------------------------------------------------------------------
// Best-fit range allocator testbench
// Drives allocate and free transfers under random stalls on both channels,
// rewrites the capacity between phases, and checks every result field
// against a cycle-free model of the free range table kept in a scoreboard.
// ----------------------------------------------------------------------------
class range_table_scoreboard;

   localparam longint unsigned OFF_MASK = 64'hFFFF_FFFF;
   localparam longint unsigned LEN_MASK = 64'h1_FFFF_FFFF;
   localparam int SLOTS = bfra_pkg::MAX_RANGES_DEF;

   typedef struct {
      longint unsigned off;
      longint unsigned size;
   } span_type;

   longint unsigned capacity;
   longint unsigned starts[SLOTS];
   longint unsigned lengths[SLOTS];
   longint unsigned alloc_total;
   longint unsigned peak_total;
   int count;
   int errors;
   logic [135:0] expected_q[$];
   span_type live[$];

   function void set_capacity(longint unsigned value);
      capacity = value & LEN_MASK;
      for (int i = 0; i < SLOTS; i++) begin
         starts[i] = 0;
         lengths[i] = 0;
      end
      lengths[0] = capacity;
      count = (capacity != 0) ? 1 : 0;
      alloc_total = 0;
      peak_total = 0;
      live.delete();
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function longint unsigned sat_add(longint unsigned a, longint unsigned b);
      longint unsigned r;
      r = a + b;
      if (r < a || r > LEN_MASK) r = LEN_MASK;
      return r;
   endfunction

   function void remove_at(int pos);
      for (int i = pos; i + 1 < count; i++) begin
         starts[i] = starts[i+1];
         lengths[i] = lengths[i+1];
      end
      count--;
   endfunction

   function void insert_at(int pos, longint unsigned s, longint unsigned l);
      for (int i = count; i > pos; i--) begin
         starts[i] = starts[i-1];
         lengths[i] = lengths[i-1];
      end
      starts[pos] = s;
      lengths[pos] = l;
      count++;
   endfunction

   function logic [1:0] allocate(longint unsigned size, longint unsigned align,
                                 output longint unsigned off);
      bit found;
      bit keep_tail;
      int best;
      longint unsigned best_al, best_slack, s, l, r, a, ld, waste, lead, trail, tail;
      found = 0;
      best = 0;
      best_al = 0;
      best_slack = 0;
      off = 0;
      for (int i = 0; i < count; i++) begin
         s = starts[i];
         l = lengths[i];
         r = s % align;
         a = s + ((r == 0) ? 0 : align - r);
         if (a > OFF_MASK) continue;
         ld = a - s;
         if (ld > l || size > l - ld) continue;
         waste = l - ld - size;
         if (!found || waste < best_slack || (waste == best_slack && a < best_al)) begin
            found = 1;
            best = i;
            best_al = a;
            best_slack = waste;
         end
      end
      if (!found) return bfra_pkg::STATUS_NO_FIT;
      lead = best_al - starts[best];
      trail = lengths[best] - lead - size;
      tail = best_al + size;
      keep_tail = (trail != 0) && (tail <= OFF_MASK);
      if (lead != 0 && keep_tail) begin
         if (count >= SLOTS) return bfra_pkg::STATUS_FULL;
         lengths[best] = lead;
         insert_at(best + 1, tail, trail);
      end else if (lead != 0) begin
         lengths[best] = lead;
      end else if (keep_tail) begin
         starts[best] = tail;
         lengths[best] = trail;
      end else begin
         remove_at(best);
      end
      alloc_total = sat_add(alloc_total, size);
      if (alloc_total > peak_total) peak_total = alloc_total;
      off = best_al;
      return bfra_pkg::STATUS_OK;
   endfunction

   function logic [1:0] release_span(longint unsigned off, longint unsigned size);
      int pos;
      bit mnext, mprev;
      longint unsigned len;
      pos = 0;
      if (size == 0) return bfra_pkg::STATUS_OK;
      while (pos < count && starts[pos] < off) pos++;
      mnext = (pos < count) && (off + size == starts[pos]);
      mprev = (pos > 0) && (starts[pos-1] + lengths[pos-1] == off);
      if (!mnext && !mprev && count >= SLOTS) return bfra_pkg::STATUS_FULL;
      len = size;
      if (mnext) len = sat_add(len, lengths[pos]);
      if (mprev) begin
         lengths[pos-1] = sat_add(lengths[pos-1], len);
         if (mnext) remove_at(pos);
      end else if (mnext) begin
         starts[pos] = off;
         lengths[pos] = len;
      end else begin
         insert_at(pos, off, len);
      end
      alloc_total = (alloc_total >= size) ? alloc_total - size : 0;
      return bfra_pkg::STATUS_OK;
   endfunction

   function void note_request(logic cmd, longint unsigned size, longint unsigned align,
                              longint unsigned off);
      logic [1:0] status;
      longint unsigned off_out, largest, free_now;
      span_type sp;
      off_out = 0;
      largest = 0;
      size &= LEN_MASK;
      align &= 64'h1_FFFF;
      off &= OFF_MASK;
      if (align == 0) align = 1;
      if (cmd == bfra_pkg::CMD_ALLOC) status = allocate(size, align, off_out);
      else status = release_span(off, size);
      if (status != bfra_pkg::STATUS_OK) off_out = 0;
      else if (cmd == bfra_pkg::CMD_ALLOC && size != 0) begin
         sp.off = off_out;
         sp.size = size;
         live.push_back(sp);
      end
      for (int i = 0; i < count; i++)
         if (lengths[i] > largest) largest = lengths[i];
      free_now = (capacity >= alloc_total) ? capacity - alloc_total : 0;
      expected_q.push_back({3'b0, peak_total[32:0], largest[32:0], free_now[32:0],
                            off_out[31:0], status});
   endfunction

   function void check_response(logic [135:0] got);
      logic [135:0] want;
      string names[5] = '{"status", "offset_out", "free_bytes", "largest_free", "peak_bytes"};
      int lsbs[5] = '{0, 2, 34, 67, 100};
      int widths[5] = '{2, 32, 33, 33, 33};
      longint unsigned mask, g, w;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result transfer, got %h", $time, got);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 5; i++) begin
         mask = (64'd1 << widths[i]) - 1;
         g = (got >> lsbs[i]) & mask;
         w = (want >> lsbs[i]) & mask;
         if (g !== w) begin
            $display("%0t: %s expected %h actual %h", $time, names[i], w, g);
            errors++;
         end
      end
   endfunction

endclass

module tb_best_fit_range_allocator;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int OB = bfra_pkg::OFFSET_BITS_DEF;
   localparam int REQ_W = ((2*OB+1+bfra_pkg::ALIGN_BITS+7)/8)*8;
   localparam int RSP_W = ((4*OB+3+bfra_pkg::STATUS_BITS+7)/8)*8;
   localparam longint unsigned LIMIT = 4_000_000;
   localparam longint unsigned CAP_MAX = 64'h1_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic req_tuser = 1'b0;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [OB:0] csr_wr_data = '0;
   logic [135:0] rsp_wide;

   range_table_scoreboard sb = new();
   bit quiet = 0;
   int stall_left = 0;
   longint unsigned cycles = 0;

   assign rsp_wide = 136'(rsp_tdata);

   best_fit_range_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb_best_fit_range_allocator: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_wide);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send(logic cmd, longint unsigned size, longint unsigned align,
                       longint unsigned off);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= REQ_W'({off[31:0], align[16:0], size[32:0]});
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, size, align, off);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(longint unsigned value);
      drain();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[OB:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_capacity(value);
   endtask

   function automatic longint unsigned rand33();
      return {31'b0, 1'($urandom_range(0, 1)), 32'($urandom)};
   endfunction

   function automatic longint unsigned pick_size();
      longint unsigned cap;
      cap = sb.capacity;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 16);
         1: return $urandom_range(1, 256);
         2: return (cap / 16 + 1) * $urandom_range(0, 1000) / 1000;
         3: return (cap / 4 + 1) * $urandom_range(0, 1000) / 1000;
         4: return rand33();
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   function automatic longint unsigned pick_align();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 64'd1 << $urandom_range(0, 16);
         2: return $urandom_range(0, 17'h1FFFF);
         default: return 64'd1 << $urandom_range(0, 8);
      endcase
   endfunction

   task automatic random_item();
      int r, k;
      longint unsigned off, size;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         send(bfra_pkg::CMD_ALLOC, pick_size(), pick_align(), $urandom);
      end else if (r < 85 && sb.live.size() != 0) begin
         k = $urandom_range(0, sb.live.size() - 1);
         off = sb.live[k].off;
         size = sb.live[k].size;
         sb.live.delete(k);
         if ($urandom_range(0, 4) == 0) size = $urandom_range(1, size > 64 ? 64 : size);
         send(bfra_pkg::CMD_FREE, size, $urandom_range(0, 17'h1FFFF), off);
      end else begin
         send(1'($urandom_range(0, 1)), rand33(), $urandom_range(0, 17'h1FFFF), $urandom);
      end
   endtask

   initial begin
      longint unsigned caps[6];
      caps = '{64'd4096, CAP_MAX, 64'd64, 64'd0, 64'd1048576, 64'd0};
      caps[5] = rand33() & 64'h1_FFFF_FFFF;
      if (caps[5] > CAP_MAX) caps[5] = CAP_MAX;
      sb.set_capacity(bfra_pkg::CAPACITY_RESET);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send(bfra_pkg::CMD_ALLOC, 0, 0, 32'hFFFF_FFFF);
      send(bfra_pkg::CMD_ALLOC, 100, 0, 0);
      send(bfra_pkg::CMD_ALLOC, 1, 65536, 0);
      send(bfra_pkg::CMD_ALLOC, CAP_MAX, 1, 0);
      send(bfra_pkg::CMD_FREE, 0, 17'h1FFFF, 50);
      send(bfra_pkg::CMD_FREE, 100, 0, 0);
      send(bfra_pkg::CMD_FREE, 40, 0, 20);
      send(bfra_pkg::CMD_ALLOC, 3, 3, 0);

      write_capacity(4096);
      for (int i = 0; i < 18; i++) send(bfra_pkg::CMD_ALLOC, 1, 64, 0);
      send(bfra_pkg::CMD_FREE, 1, 0, 32'hFFFF_FFF0);
      send(bfra_pkg::CMD_FREE, 1, 0, 64);

      write_capacity(CAP_MAX);
      send(bfra_pkg::CMD_ALLOC, CAP_MAX, 1, 0);
      send(bfra_pkg::CMD_FREE, 256, 0, 32'hFFFF_FFF0);
      send(bfra_pkg::CMD_ALLOC, 1, 65536, 0);
      send(bfra_pkg::CMD_ALLOC, 16, 16, 0);

      write_capacity(0);
      send(bfra_pkg::CMD_FREE, 32'hFFFF_FFFF, 0, 0);
      send(bfra_pkg::CMD_FREE, 64'h1_FFFF_FFFF, 0, 32'hFFFF_FFFF);
      send(bfra_pkg::CMD_ALLOC, 64'h1_FFFF_FFFF, 0, 0);
      send(bfra_pkg::CMD_FREE, 64'h1_FFFF_FFFF, 0, 0);

      foreach (caps[p]) begin
         write_capacity(caps[p]);
         quiet = (p == 5);
         for (int n = 0; n < 165; n++) begin
            if (p == 1 && n == 80) drain();
            random_item();
         end
      end

      drain();
      repeat (2000) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_best_fit_range_allocator: done, clean");
      end else begin
         $display("tb_best_fit_range_allocator: done, errors");
      end
      $finish;
   end

endmodule
